// ===== rtl/core/nefx_pkg.sv =====
// Shared types and constants for the NE export table and import fixup unit.
package nefx_pkg;

	typedef enum logic [2:0] {
		ST_NOT_IMPORT = 3'd0,
		ST_BAD_MODULE = 3'd1,
		ST_BAD_ORDINAL = 3'd2,
		ST_RESOLVED = 3'd3,
		ST_PATCHED = 3'd4,
		ST_BYTE_TAKEN = 3'd5,
		ST_MOD_CLOSED = 3'd6,
		ST_SLOTS_FULL = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		PH_COUNT = 4'b0001,
		PH_KIND = 4'b0010,
		PH_FIXED = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic wr_en;
		logic close;
		status_t status;
	} parse_res_t;

	localparam logic [7:0] KIND_UNUSED = 8'h00;
	localparam logic [7:0] KIND_MOVEABLE = 8'hFF;
	localparam logic [7:0] ADDR_FAR_PTR = 8'd3;
	localparam logic [7:0] RELOC_IMP_ORD = 8'd1;
	localparam logic [3:0] MOVE_ENTRY_BYTES = 4'd6;
	localparam logic [16:0] FAR_PTR_TAIL = 17'd3;
	localparam logic [15:0] SELECTOR_RESET = 16'h0048;

endpackage

// ===== rtl/core/ne_export_table_and_import_fixup_unit.sv =====
// Top level: export store, import-by-ordinal resolver and item pipeline.
//
// Takes one item per cycle unless m_tready stalls the pipeline, and returns one result
// per item: acceptance registers the item in stage 1 together with the export-store
// read for a relocation record, then the result register takes the result. Entry-table
// bytes fill the next free module slot; relocation records see closed modules
// only. Input tuser is operation; input tdata is, from bit 0: entry_byte,
// reloc_address_kind, reloc_kind, patch_location, module_number,
// import_ordinal, segment_size. Output tuser is status; output tdata is, from
// bit 0: resolved_offset, resolved_selector, patch_offset, patch_valid,
// exports_found. The only stall source is m_tready.
module ne_export_table_and_import_fixup_unit #(
	parameter int MODULE_SLOTS = 4,
	parameter int EXPORT_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,  // import_selector
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,      // entry_byte, reloc_address_kind, reloc_kind,
	                                  // patch_location, module_number,
	                                  // import_ordinal, segment_size
	input  logic [0:0]  s_tuser,      // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,      // resolved_offset, resolved_selector,
	                                  // patch_offset, patch_valid, exports_found
	output logic [2:0]  m_tuser       // status
);
	import nefx_pkg::*;

	localparam int DEPTH = MODULE_SLOTS * EXPORT_SLOTS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MIW = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;
	localparam int OIW = (EXPORT_SLOTS > 1) ? $clog2(EXPORT_SLOTS) : 1;
	localparam int MLW = $clog2(MODULE_SLOTS + 1);
	localparam int CW = $clog2(EXPORT_SLOTS + 1);

	logic [15:0] sel_q;

	// stage 1
	logic        vld_s1;
	logic        op_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  akind_s1;
	logic [7:0]  rkind_s1;
	logic [15:0] loc_s1;
	logic [15:0] mod_s1;
	logic [15:0] ord_s1;
	logic [15:0] size_s1;
	logic [15:0] rd_data_s1;
	logic        rd_vld_s1;

	// result register
	logic        vld_q;
	status_t     status_q;
	logic [15:0] off_q;
	logic [15:0] rsel_q;
	logic [15:0] poff_q;
	logic        pv_q;
	logic [5:0]  found_q;

	logic [15:0] store_mem [DEPTH];
	logic        store_vld_q [DEPTH];
	logic [CW-1:0] cnt_q [MODULE_SLOTS];

	logic        adv;
	logic        accept;
	logic        step;
	logic [15:0] in_mod_m1;
	logic [15:0] in_ord_m1;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;

	parse_res_t  pres;
	logic [MLW-1:0] mods;
	logic [OIW-1:0] wr_ord;
	logic [15:0] wr_data;
	logic [CW-1:0] cur_count;

	logic [15:0] mod_m1_s1;
	logic [CW-1:0] mod_cnt;
	logic        mod_ok;
	logic        ord_ok;
	logic        patch_ok;
	logic [15:0] found_off;

	status_t     status_d;
	logic [15:0] off_d;
	logic [15:0] rsel_d;
	logic [15:0] poff_d;
	logic        pv_d;
	logic [5:0]  found_d;

	assign adv = !vld_q || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign accept = s_tvalid && s_tready;
	assign step = vld_s1 && adv && !op_s1;

	assign in_mod_m1 = s_tdata[55:40] - 16'd1;
	assign in_ord_m1 = s_tdata[71:56] - 16'd1;
	assign raddr = AW'(32'(in_mod_m1[MIW-1:0]) * 32'(EXPORT_SLOTS) + 32'(in_ord_m1[OIW-1:0]));
	assign waddr = AW'(32'(mods) * 32'(EXPORT_SLOTS) + 32'(wr_ord));

	nefx_entry_parser #(
		.MODULE_SLOTS (MODULE_SLOTS),
		.EXPORT_SLOTS (EXPORT_SLOTS),
		.MLW          (MLW),
		.OIW          (OIW),
		.CW           (CW)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.entry_byte     (byte_s1),
		.res            (pres),
		.modules_loaded (mods),
		.wr_ord         (wr_ord),
		.wr_data        (wr_data),
		.cur_count      (cur_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= SELECTOR_RESET;
		end else if (cfg_wr_en) begin
			sel_q <= cfg_wr_data;
		end
	end

	// export store: write from the parser, read when an item is taken in
	always_ff @(posedge clk) begin
		if (step && pres.wr_en) begin
			store_mem[waddr] <= wr_data;
		end
		if (accept) begin
			rd_data_s1 <= store_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				store_vld_q[i] <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
		end else begin
			if (step && pres.wr_en) begin
				store_vld_q[waddr] <= 1'b1;
			end
			if (accept) begin
				rd_vld_s1 <= store_vld_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && pres.close) begin
			cnt_q[mods[MIW-1:0]] <= cur_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= s_tuser[0];
			byte_s1 <= s_tdata[7:0];
			akind_s1 <= s_tdata[15:8];
			rkind_s1 <= s_tdata[23:16];
			loc_s1 <= s_tdata[39:24];
			mod_s1 <= s_tdata[55:40];
			ord_s1 <= s_tdata[71:56];
			size_s1 <= s_tdata[87:72];
		end
	end

	assign mod_m1_s1 = mod_s1 - 16'd1;
	assign mod_cnt = cnt_q[mod_m1_s1[MIW-1:0]];
	assign mod_ok = (mod_s1 != 16'd0) && (mod_s1 <= 16'(mods));
	assign ord_ok = (ord_s1 != 16'd0) && (ord_s1 <= 16'(mod_cnt))
		&& (ord_s1 <= 16'(EXPORT_SLOTS));
	assign patch_ok = (akind_s1 == ADDR_FAR_PTR)
		&& ((17'(loc_s1) + FAR_PTR_TAIL) < 17'(size_s1));
	assign found_off = rd_vld_s1 ? rd_data_s1 : 16'd0;

	always_comb begin
		status_d = ST_NOT_IMPORT;
		off_d = '0;
		rsel_d = '0;
		poff_d = '0;
		pv_d = 1'b0;
		found_d = '0;
		if (!op_s1) begin
			status_d = pres.status;
			if (pres.close) begin
				found_d = 6'(cur_count);
			end
		end else if (rkind_s1 != RELOC_IMP_ORD) begin
			status_d = ST_NOT_IMPORT;
		end else if (!mod_ok) begin
			status_d = ST_BAD_MODULE;
		end else if (!ord_ok) begin
			status_d = ST_BAD_ORDINAL;
		end else begin
			off_d = found_off;
			rsel_d = sel_q;
			if (patch_ok) begin
				status_d = ST_PATCHED;
				poff_d = loc_s1;
				pv_d = 1'b1;
			end else begin
				status_d = ST_RESOLVED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			status_q <= status_d;
			off_q <= off_d;
			rsel_q <= rsel_d;
			poff_q <= poff_d;
			pv_q <= pv_d;
			found_q <= found_d;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tuser = status_q;
	assign m_tdata = {1'b0, found_q, pv_q, poff_q, rsel_q, off_q};

endmodule

// ===== rtl/core/nefx_entry_parser.sv =====
// Entry-table byte parser: group walk, ordinal tracking and module closing.
module nefx_entry_parser #(
	parameter int MODULE_SLOTS = 4,
	parameter int EXPORT_SLOTS = 32,
	parameter int MLW = 3,
	parameter int OIW = 5,
	parameter int CW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           entry_byte,
	output nefx_pkg::parse_res_t res,
	output logic [MLW-1:0]       modules_loaded,
	output logic [OIW-1:0]       wr_ord,
	output logic [15:0]          wr_data,
	output logic [CW-1:0]        cur_count
);
	import nefx_pkg::*;

	phase_t       phase_q, phase_d;
	logic [7:0]   group_q, group_d;
	logic [10:0]  skip_q, skip_d;
	logic [1:0]   idx_q, idx_d;
	logic [7:0]   low_q, low_d;
	logic [15:0]  ord_q, ord_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [MLW-1:0] mods_q, mods_d;
	logic         full;
	logic [8:0]   ord_inc;

	assign full = (mods_q == MLW'(MODULE_SLOTS));
	assign ord_inc = 9'(ord_q[7:0]) + 9'd1;
	assign modules_loaded = mods_q;
	assign wr_ord = ord_q[OIW-1:0];
	assign wr_data = {entry_byte, low_q};
	assign cur_count = cnt_q;

	always_comb begin
		phase_d = phase_q;
		group_d = group_q;
		skip_d = skip_q;
		idx_d = idx_q;
		low_d = low_q;
		ord_d = ord_q;
		cnt_d = cnt_q;
		mods_d = mods_q;
		res.wr_en = 1'b0;
		res.close = 1'b0;
		res.status = ST_BYTE_TAKEN;
		if (full) begin
			res.status = ST_SLOTS_FULL;
		end else begin
			case (phase_q)
				PH_KIND: begin
					if (entry_byte == KIND_UNUSED) begin
						ord_d = ord_q + 16'(group_q);
						phase_d = PH_COUNT;
					end else if (entry_byte == KIND_MOVEABLE) begin
						skip_d = 11'(group_q) * 11'(MOVE_ENTRY_BYTES);
						ord_d = ord_q + 16'(group_q);
						phase_d = PH_SKIP;
					end else begin
						idx_d = 2'd0;
						phase_d = PH_FIXED;
					end
				end
				PH_FIXED: begin
					if (idx_q == 2'd0) begin
						idx_d = 2'd1;
					end else if (idx_q == 2'd1) begin
						low_d = entry_byte;
						idx_d = 2'd2;
					end else begin
						if (ord_q < 16'(EXPORT_SLOTS)) begin
							res.wr_en = 1'b1;
							if (CW'(ord_inc) > cnt_q) begin
								cnt_d = CW'(ord_inc);
							end
						end
						ord_d = ord_q + 16'd1;
						idx_d = 2'd0;
						group_d = group_q - 8'd1;
						if (group_q == 8'd1) begin
							phase_d = PH_COUNT;
						end
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 11'd1;
					if (skip_q == 11'd1) begin
						phase_d = PH_COUNT;
					end
				end
				default: begin
					if (entry_byte == 8'd0) begin
						res.close = 1'b1;
						res.status = ST_MOD_CLOSED;
						mods_d = mods_q + MLW'(1);
						ord_d = '0;
						group_d = '0;
						skip_d = '0;
						idx_d = '0;
						low_d = '0;
						cnt_d = '0;
						phase_d = PH_COUNT;
					end else begin
						group_d = entry_byte;
						phase_d = PH_KIND;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			group_q <= '0;
			skip_q <= '0;
			idx_q <= '0;
			low_q <= '0;
			ord_q <= '0;
			cnt_q <= '0;
			mods_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			group_q <= group_d;
			skip_q <= skip_d;
			idx_q <= idx_d;
			low_q <= low_d;
			ord_q <= ord_d;
			cnt_q <= cnt_d;
			mods_q <= mods_d;
		end
	end

endmodule

// ===== tb/ne_export_table_and_import_fixup_unit_test.sv =====
// Testbench for the NE export table and import fixup unit: predicted results checked per item.
`timescale 1ns / 1ps

module ne_export_table_and_import_fixup_unit_test;
	import nefx_pkg::*;

	localparam int MODULE_SLOTS = 4;
	localparam int EXPORT_SLOTS = 32;
	localparam logic OP_ENTRY = 1'b0;
	localparam logic OP_RELOC = 1'b1;
	localparam logic [7:0] END_OF_TABLE = 8'h00;
	localparam logic [7:0] ADDR_OTHER = 8'h02;
	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		status_t status;
		logic [15:0] offset;
		logic [15:0] selector;
		logic [15:0] patch_at;
		logic patch_valid;
		logic [5:0] found;
	} fixup_result_t;

	class fixup_scoreboard;
		logic [15:0] selector;
		phase_t phase;
		logic [7:0] grp_left;
		logic [15:0] skip_left;
		logic [1:0] byte_idx;
		logic [7:0] offset_lo;
		logic [15:0] ordinal;
		logic [15:0] exports [MODULE_SLOTS * EXPORT_SLOTS];
		logic [6:0] ecount [MODULE_SLOTS];
		int mods_closed;
		fixup_result_t pending_fixups [$];
		int errors;
		int checked;
		int seen [8];

		function new();
			selector = SELECTOR_RESET;
			phase = PH_COUNT;
			grp_left = '0;
			skip_left = '0;
			byte_idx = '0;
			offset_lo = '0;
			ordinal = '0;
			foreach (exports[i]) exports[i] = '0;
			foreach (ecount[i]) ecount[i] = '0;
			foreach (seen[i]) seen[i] = 0;
			mods_closed = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void take_item(logic op, logic [87:0] d);
			fixup_result_t r;
			logic [7:0] b;
			int mod_n;
			int ord_n;
			r = '0;
			b = d[7:0];
			if (op == OP_ENTRY) begin
				if (mods_closed >= MODULE_SLOTS) begin
					r.status = ST_SLOTS_FULL;
				end else begin
					r.status = ST_BYTE_TAKEN;
					case (phase)
					PH_KIND: begin
						if (b == KIND_UNUSED) begin
							ordinal = ordinal + 16'(grp_left);
							phase = PH_COUNT;
						end else if (b == KIND_MOVEABLE) begin
							skip_left = 16'(grp_left) * 16'(MOVE_ENTRY_BYTES);
							ordinal = ordinal + 16'(grp_left);
							phase = PH_SKIP;
						end else begin
							byte_idx = 2'd0;
							phase = PH_FIXED;
						end
					end
					PH_FIXED: begin
						if (byte_idx == 2'd0) begin
							byte_idx = 2'd1;
						end else if (byte_idx == 2'd1) begin
							offset_lo = b;
							byte_idx = 2'd2;
						end else begin
							if (ordinal < EXPORT_SLOTS) begin
								exports[mods_closed * EXPORT_SLOTS + int'(ordinal)] = {b, offset_lo};
								if (int'(ordinal) + 1 > int'(ecount[mods_closed]))
									ecount[mods_closed] = 7'(ordinal + 16'd1);
							end
							ordinal = ordinal + 16'd1;
							byte_idx = 2'd0;
							grp_left = grp_left - 8'd1;
							if (grp_left == 8'd0)
								phase = PH_COUNT;
						end
					end
					PH_SKIP: begin
						skip_left = skip_left - 16'd1;
						if (skip_left == 16'd0)
							phase = PH_COUNT;
					end
					default: begin
						if (b == END_OF_TABLE) begin
							r.status = ST_MOD_CLOSED;
							r.found = ecount[mods_closed][5:0];
							mods_closed++;
							ordinal = '0;
							grp_left = '0;
							skip_left = '0;
							byte_idx = '0;
							offset_lo = '0;
							phase = PH_COUNT;
						end else begin
							grp_left = b;
							phase = PH_KIND;
						end
					end
					endcase
				end
			end else begin
				mod_n = int'(d[55:40]);
				ord_n = int'(d[71:56]);
				if (d[23:16] != RELOC_IMP_ORD) begin
					r.status = ST_NOT_IMPORT;
				end else if (mod_n < 1 || mod_n > mods_closed) begin
					r.status = ST_BAD_MODULE;
				end else if (ord_n < 1 || ord_n > int'(ecount[mod_n - 1]) || ord_n > EXPORT_SLOTS) begin
					r.status = ST_BAD_ORDINAL;
				end else begin
					r.offset = exports[(mod_n - 1) * EXPORT_SLOTS + ord_n - 1];
					r.selector = selector;
					// bound check is done in 17 bits so that it cannot wrap
					if (d[15:8] == ADDR_FAR_PTR && {1'b0, d[39:24]} + FAR_PTR_TAIL < {1'b0, d[87:72]}) begin
						r.status = ST_PATCHED;
						r.patch_at = d[39:24];
						r.patch_valid = 1'b1;
					end else begin
						r.status = ST_RESOLVED;
					end
				end
			end
			pending_fixups.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("%s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_result(logic [2:0] st, logic [55:0] d);
			fixup_result_t e;
			if (pending_fixups.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("result with no item outstanding, status %0d", st);
				return;
			end
			e = pending_fixups.pop_front();
			checked++;
			seen[e.status]++;
			compare_field("status", 16'(e.status), 16'(st));
			compare_field("resolved_offset", e.offset, d[15:0]);
			compare_field("resolved_selector", e.selector, d[31:16]);
			compare_field("patch_offset", e.patch_at, d[47:32]);
			compare_field("patch_valid", 16'(e.patch_valid), 16'(d[48]));
			compare_field("exports_found", 16'(e.found), 16'(d[54:49]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [87:0] s_tdata = '0;  // entry_byte, reloc_address_kind, reloc_kind, patch_location,
	                            // module_number, import_ordinal, segment_size
	logic [0:0] s_tuser = '0;   // operation
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;       // resolved_offset, resolved_selector, patch_offset,
	                            // patch_valid, exports_found
	logic [2:0] m_tuser;        // status

	fixup_scoreboard sb;
	int items_sent = 0;
	int burst_left = 0;
	int selector_writes = 0;
	int stall_cycles = 0;
	bit hold_off_req = 1'b0;

	ne_export_table_and_import_fixup_unit #(
		.MODULE_SLOTS(MODULE_SLOTS),
		.EXPORT_SLOTS(EXPORT_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_item(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$error("no item moved for %0d cycles", stall_cycles);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver: changing stall patterns, plus one long hold-off on request
	initial begin : receiver
		int rx_mode;
		int rx_count;
		rx_mode = 0;
		rx_count = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (rx_count % 97 == 0)
					rx_mode = $urandom_range(0, 3);
				rx_count++;
				case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_count % 4 == 0);
				default: m_tready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	task automatic send_item(logic op, logic [87:0] d);
		int gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
			0, 1, 2: gap = 0;
			3, 4, 5, 6, 7: gap = $urandom_range(1, 4);
			default: gap = $urandom_range(5, 30);
			endcase
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic send_entry(logic [7:0] b);
		send_item(OP_ENTRY, {32'($urandom), 32'($urandom), 16'($urandom), b});
	endtask

	task automatic send_reloc(logic [7:0] addr, logic [7:0] kind, logic [15:0] loc,
			logic [15:0] mod_n, logic [15:0] ord_n, logic [15:0] size);
		send_item(OP_RELOC, {size, ord_n, mod_n, loc, kind, addr, 8'($urandom)});
	endtask

	task automatic random_reloc();
		int r;
		int closed;
		int mod_n;
		int ord_n;
		int cnt;
		logic [7:0] addr;
		logic [7:0] kind;
		logic [15:0] loc;
		logic [15:0] size;
		closed = sb.mods_closed;
		r = $urandom_range(0, 99);
		if (r < 75)
			mod_n = $urandom_range(1, closed > 0 ? closed : 1);
		else if (r < 85)
			mod_n = closed + 1;
		else if (r < 92)
			mod_n = 0;
		else
			mod_n = $urandom_range(0, 65535);
		cnt = (mod_n >= 1 && mod_n <= MODULE_SLOTS) ? int'(sb.ecount[mod_n - 1]) : 1;
		r = $urandom_range(0, 99);
		if (r < 70)
			ord_n = $urandom_range(1, cnt > 0 ? cnt : 1);
		else if (r < 80)
			ord_n = cnt + 1;
		else if (r < 85)
			ord_n = 0;
		else if (r < 90)
			ord_n = EXPORT_SLOTS + $urandom_range(0, 1);
		else
			ord_n = $urandom_range(0, 65535);
		kind = ($urandom_range(0, 99) < 85) ? RELOC_IMP_ORD : 8'($urandom_range(0, 255));
		addr = ($urandom_range(0, 99) < 75) ? ADDR_FAR_PTR : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 40) begin
			loc = 16'($urandom_range(0, 65535));
			size = 16'($urandom_range(0, 65535));
		end else if (r < 70) begin
			// straddle the patch bound
			loc = 16'($urandom_range(0, 65530));
			size = loc + 16'd3 + 16'($urandom_range(0, 2));
		end else if (r < 80) begin
			loc = 16'($urandom_range(65530, 65535));
			size = 16'hFFFF;
		end else begin
			loc = 16'($urandom_range(0, 16));
			size = 16'($urandom_range(0, 16));
		end
		send_reloc(addr, kind, loc, 16'(mod_n), 16'(ord_n), size);
	endtask

	task automatic emit_byte(logic [7:0] b, int pct);
		if ($urandom_range(0, 99) < pct)
			random_reloc();
		send_entry(b);
	endtask

	// one complete entry table, relocation records mixed in at random
	task automatic build_module(int n_groups, int pct, bit wrap);
		int g;
		int r;
		int c;
		int payload;
		logic [7:0] kind;
		if (wrap) begin
			// 257 unused groups of 255 take the ordinal to 0xFFFF
			repeat (257) begin
				emit_byte(8'hFF, pct);
				emit_byte(KIND_UNUSED, pct);
			end
		end
		for (g = 0; g < n_groups; g++) begin
			r = (wrap && g == 0) ? 0 : $urandom_range(0, 99);
			if (r < 45) begin
				if (wrap && g == 0)
					c = 3;
				else
					c = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				case ($urandom_range(0, 9))
				0: kind = 8'h01;
				1: kind = 8'hFE;
				default: kind = 8'($urandom_range(1, 254));
				endcase
			end else if (r < 65) begin
				c = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 6);
				kind = KIND_UNUSED;
			end else if (r < 85) begin
				c = $urandom_range(1, 3);
				kind = KIND_MOVEABLE;
			end else begin
				c = $urandom_range(1, 3);
				kind = 8'($urandom_range(0, 255));
			end
			if (kind == KIND_UNUSED)
				payload = 0;
			else if (kind == KIND_MOVEABLE)
				payload = c * int'(MOVE_ENTRY_BYTES);
			else
				payload = c * 3;
			emit_byte(8'(c), pct);
			emit_byte(kind, pct);
			repeat (payload) emit_byte(8'($urandom), pct);
		end
		emit_byte(END_OF_TABLE, pct);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending_fixups.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_selector(logic [15:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.selector = v;
		selector_writes++;
	endtask

	localparam logic [7:0] FIRST_TABLE [22] = '{
		8'h02, 8'hFE, 8'h5A, 8'hFF, 8'hFF, 8'hA5, 8'h00, 8'h00,
		8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F,
		8'h01, 8'h01, 8'h00, 8'h34, 8'h12, 8'h00
	};

	initial begin : stimulus
		int k;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open module is invisible
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h0000, 16'd1, 16'd1, 16'h0004);
		// fixed pair, moveable skip holding a zero byte, fixed entry after a gap, close
		foreach (FIRST_TABLE[i]) send_entry(FIRST_TABLE[i]);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h0000, 16'd1, 16'd1, 16'h0004);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'hFFFF, 16'd1, 16'd3, 16'hFFFF);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h000A, 16'd1, 16'd4, 16'h000D);
		send_reloc(ADDR_OTHER, RELOC_IMP_ORD, 16'h0000, 16'd1, 16'd2, 16'hFFFF);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h0000, 16'd1, 16'd5, 16'hFFFF);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h0000, 16'd0, 16'd1, 16'hFFFF);
		send_reloc(ADDR_FAR_PTR, RELOC_IMP_ORD, 16'h0000, 16'd2, 16'd1, 16'hFFFF);
		send_reloc(ADDR_FAR_PTR, ~RELOC_IMP_ORD, 16'h0000, 16'd1, 16'd1, 16'hFFFF);

		set_selector(16'hFFFF);
		build_module(6, 25, 1'b0);
		repeat (150) random_reloc();

		set_selector(16'h0000);
		hold_off_req = 1'b1;
		build_module(4, 10, 1'b1);
		repeat (60) random_reloc();

		set_selector(16'($urandom_range(1, 16'hFFFE)));
		build_module(8, 25, 1'b0);

		// all slots taken: entry bytes are now dropped
		for (k = 0; k < 2 || items_sent < RANDOM_ITEMS + 31; k++) begin
			case (k % 3)
			0: set_selector(16'hFFFF);
			1: set_selector(16'h0000);
			default: set_selector(16'($urandom_range(0, 65535)));
			endcase
			repeat (150) begin
				if ($urandom_range(0, 99) < 85)
					random_reloc();
				else
					send_entry(8'($urandom));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		$display("covered %0d items, %0d results, %0d modules closed, %0d selector writes",
			items_sent, sb.checked, sb.mods_closed, selector_writes);
		$display("by status: %0d not-import %0d bad-module %0d bad-ordinal %0d resolved",
			sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
		$display("           %0d patched %0d taken %0d closed %0d full",
			sb.seen[4], sb.seen[5], sb.seen[6], sb.seen[7]);
		if (sb.pending_fixups.size() != 0)
			$error("%0d results never arrived", sb.pending_fixups.size());
		if (sb.errors == 0 && sb.pending_fixups.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/nefx_pkg.sv
rtl/core/nefx_entry_parser.sv
rtl/core/ne_export_table_and_import_fixup_unit.sv
tb/ne_export_table_and_import_fixup_unit_test.sv
